// ===== src/dtoi_pkg.sv =====
// Shared types and constants for the decimal text to integer unit.
package dtoi_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [1:0] CLS_SPACE = 2'd0;
    localparam logic [1:0] CLS_SIGN  = 2'd1;
    localparam logic [1:0] CLS_DIGIT = 2'd2;
    localparam logic [1:0] CLS_OTHER = 2'd3;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [63:0] MAX32 = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] MIN32 = 64'hFFFF_FFFF_8000_0000;
    localparam logic [63:0] MAX64 = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
    localparam logic [63:0] DIV32 = MAX32 / 64'd10;
    localparam logic [63:0] DIV64 = MAX64 / 64'd10;
    localparam logic [3:0]  REM32 = 4'(MAX32 % 64'd10);
    localparam logic [3:0]  REM64 = 4'(MAX64 % 64'd10);

    typedef struct packed {
        logic       start;
        logic [1:0] cls;
        logic       minus;
        logic [3:0] digit;
    } entry_t;

endpackage

// ===== src/dtoi_char_if.sv =====
// Character channel: one byte of text per item.
interface dtoi_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       string_start;

    modport source (output valid, char_code, string_start, input ready);
    modport sink   (input valid, char_code, string_start, output ready);
endinterface

// ===== src/dtoi_result_if.sv =====
// Result channel: one converted integer per item.
interface dtoi_result_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] value;
    logic               saturated;

    modport source (output valid, value, saturated, input ready);
    modport sink   (input valid, value, saturated, output ready);
endinterface

// ===== src/dtoi_front.sv =====
// Front end: takes characters and classifies them for the queue.
module dtoi_front (
    dtoi_char_if.sink      char_in,
    input  logic           q_full,
    output logic           q_push,
    output dtoi_pkg::entry_t q_entry
);
    import dtoi_pkg::*;

    logic [7:0] c;
    logic       is_digit;
    logic       is_space;
    logic       is_sign;

    assign c        = char_in.char_code;
    assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    assign is_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    assign is_sign  = (c == CH_PLUS) || (c == CH_MINUS);

    assign char_in.ready = !q_full;
    assign q_push        = char_in.valid && !q_full;

    always_comb
    begin
        q_entry.start = char_in.string_start;
        q_entry.minus = (c == CH_MINUS);
        q_entry.digit = 4'(c - CH_ZERO);
        priority if (is_space)
        begin
            q_entry.cls = CLS_SPACE;
        end
        else if (is_sign)
        begin
            q_entry.cls = CLS_SIGN;
        end
        else if (is_digit)
        begin
            q_entry.cls = CLS_DIGIT;
        end
        else
        begin
            q_entry.cls = CLS_OTHER;
        end
    end
endmodule

// ===== src/dtoi_queue.sv =====
// Short FIFO of classified characters between front and back.
module dtoi_queue #(
    parameter int DEPTH = dtoi_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  dtoi_pkg::entry_t push_entry,
    input  logic             pop,
    output logic             full,
    output logic             head_valid,
    output dtoi_pkg::entry_t head_entry
);
    import dtoi_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    entry_t           mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_pop;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_entry = mem_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end
endmodule

// ===== src/dtoi_back.sv =====
// Back end: parser state, digit accumulation, saturation and result register.
module dtoi_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             width_mode,
    input  logic             head_valid,
    input  dtoi_pkg::entry_t head_entry,
    output logic             pop,
    dtoi_result_if.source    result_out
);
    import dtoi_pkg::*;

    localparam logic [1:0] PH_SKIP = 2'd0;
    localparam logic [1:0] PH_NUM  = 2'd1;
    localparam logic [1:0] PH_DONE = 2'd2;

    logic [1:0]  phase_reg, phase_next;
    logic        neg_reg, neg_next;
    logic [63:0] mag_reg, mag_next;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] value_reg, value_next;
    logic        sat_reg, sat_next;

    logic [1:0]  ph;
    logic        neg;
    logic [63:0] mag;
    logic [63:0] mx, mn, dv;
    logic [3:0]  rm;
    logic        emit;
    logic        sat;
    logic        ovf;
    logic        number;

    assign pop = head_valid && (!out_valid_reg || result_out.ready);

    assign mx = width_mode ? MAX64 : MAX32;
    assign mn = width_mode ? MIN64 : MIN32;
    assign dv = width_mode ? DIV64 : DIV32;
    assign rm = width_mode ? REM64 : REM32;

    assign ph  = head_entry.start ? PH_SKIP : phase_reg;
    assign neg = head_entry.start ? 1'b0 : neg_reg;
    assign mag = head_entry.start ? 64'd0 : mag_reg;
    assign ovf = (mag > dv) || ((mag == dv) && (head_entry.digit > rm));

    always_comb
    begin
        phase_next     = phase_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        emit           = 1'b0;
        sat            = 1'b0;
        number         = 1'b0;
        if (pop)
        begin
            phase_next = ph;
            neg_next   = neg;
            mag_next   = mag;
            unique case (ph)
                PH_SKIP:
                begin
                    unique case (head_entry.cls)
                        CLS_SPACE: ;
                        CLS_SIGN:
                        begin
                            neg_next   = head_entry.minus;
                            phase_next = PH_NUM;
                        end
                        default:
                        begin
                            number = 1'b1;
                        end
                    endcase
                end
                PH_NUM:
                begin
                    number = 1'b1;
                end
                default: ;
            endcase
            if (number)
            begin
                phase_next = PH_NUM;
                if (head_entry.cls != CLS_DIGIT)
                begin
                    emit = 1'b1;
                end
                else if (ovf)
                begin
                    emit = 1'b1;
                    sat  = 1'b1;
                end
                else
                begin
                    mag_next = (mag << 3) + (mag << 1) + {60'd0, head_entry.digit};
                end
                if (emit)
                begin
                    phase_next = PH_DONE;
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        value_next     = value_reg;
        sat_next       = sat_reg;
        if (result_out.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
            sat_next       = sat || (mag > mx);
            if (sat_next)
            begin
                value_next = neg ? mn : mx;
            end
            else
            begin
                value_next = neg ? (64'd0 - mag) : mag;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SKIP;
            neg_reg       <= 1'b0;
            mag_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            neg_reg       <= neg_next;
            mag_reg       <= mag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        sat_reg   <= sat_next;
    end

    assign result_out.valid     = out_valid_reg;
    assign result_out.value     = value_reg;
    assign result_out.saturated = sat_reg;
endmodule

// ===== src/decimal_text_to_integer_unit.sv =====
// Top level of the decimal text to integer unit.
//
//  channel     dir  payload                      handshake
//  char_in     in   char_code[7:0], string_start valid/ready
//  result_out  out  value[63:0] (signed), saturated valid/ready
//  cfg         in   cfg_wdata (width_mode)       cfg_we, no wait
//
// One character per cycle sustained unless a result stalls; the back end's 64-bit
// times-ten add and limit compare are combinational, ahead of the accumulator register.
// With the queue empty and the result register free, the character that ends a
// number is written to the queue, popped by the back end and the result registered.
// Reset clears the parser, queue and result valid; the first string needs no start mark.
// A stalled result holds the back end; the front keeps taking items until the queue fills.
module decimal_text_to_integer_unit #(
    parameter int QUEUE_DEPTH = dtoi_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_wdata,
    dtoi_char_if.sink        char_in,
    dtoi_result_if.source    result_out
);
    import dtoi_pkg::*;

    logic   width_mode_reg;
    logic   q_full;
    logic   q_push;
    logic   q_pop;
    logic   q_head_valid;
    entry_t q_entry;
    entry_t q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            width_mode_reg <= cfg_wdata;
        end
    end

    dtoi_front u_front (
        .char_in (char_in),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_entry (q_entry)
    );

    dtoi_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_head_valid),
        .head_entry (q_head)
    );

    dtoi_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .width_mode (width_mode_reg),
        .head_valid (q_head_valid),
        .head_entry (q_head),
        .pop        (q_pop),
        .result_out (result_out)
    );

    a_sat32_limits: assert property (@(posedge clk) disable iff (!rst_n)
        (result_out.valid && result_out.saturated && !width_mode_reg) |->
        (result_out.value == MAX32 || result_out.value == MIN32))
        else $error("32-bit saturated result is not a limit");

    a_sat64_limits: assert property (@(posedge clk) disable iff (!rst_n)
        (result_out.valid && result_out.saturated && width_mode_reg) |->
        (result_out.value == MAX64 || result_out.value == MIN64))
        else $error("64-bit saturated result is not a limit");

    a_range32: assert property (@(posedge clk) disable iff (!rst_n)
        (result_out.valid && !width_mode_reg) |->
        (result_out.value[63:31] == '0 || result_out.value[63:31] == '1))
        else $error("32-bit result outside sign-extended range");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_head_valid)
        else $error("back end took an item from an empty queue");
endmodule
